@@ rtl/core/degree_histogram_tracker_macros.svh @@
// Assertion macros for the degree histogram tracker.
`ifndef DEGREE_HISTOGRAM_TRACKER_MACROS_SVH
`define DEGREE_HISTOGRAM_TRACKER_MACROS_SVH

`ifndef SYNTH
// Checked only out of reset.
`define DHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define DHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DHT_ASSERT(lbl, prop, msg)
`define DHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/dht_pkg.sv @@
// Package: widths, codes and sequencer states of the degree histogram tracker.
package dht_pkg;

  localparam int NUM_VERTICES = 1024;
  localparam int MAX_DEGREE   = 1023;

  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int VTX_W  = 10;
  localparam int DEG_W  = 10;
  localparam int CNT_W  = 11;
  localparam int SUM_W  = 20;
  localparam int EDGE_W = 19;
  localparam int DEG_DEPTH = MAX_DEGREE + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SET    = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UNDER = 2'd1,
    STATUS_OVER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RDB,
    S_CALC,
    S_HRD,
    S_HWR,
    S_CRD,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/degree_histogram_tracker.sv @@
// Top level: degree histogram tracker with sequencer, degree RAM and histogram RAM.
//
// Input channel (in_*): one transfer per item; mode selects add edge, remove
// edge, set vertex degree or query histogram count. Result channel (out_*):
// exactly one transfer per item, in input order.
// One item is in work at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// Steps per item: read both vertex degrees, evaluate the move and write back
// the first degree, then do the histogram updates (query or rejected move:
// none; set degree or self-loop: two; edge between two vertices: four),
// the second degree being written with the first update's write-back.
// Each histogram update is a read followed by a write-back, and a final
// histogram read gives the reported count.
// Reset: a clearing pass zeroes every degree and loads the
// histogram (1024 at degree zero, zero elsewhere); in_stall stays high
// during the pass.
// A stalled result holds in the output register while the next item is
// accepted and worked; that item waits in its last state until out is free.
`include "degree_histogram_tracker_macros.svh"

module degree_histogram_tracker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [dht_pkg::MODE_W-1:0] in_mode,
  input  logic [dht_pkg::VTX_W-1:0]  in_first_vertex,
  input  logic [dht_pkg::VTX_W-1:0]  in_second_vertex,
  input  logic [dht_pkg::DEG_W-1:0]  in_degree_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [dht_pkg::STAT_W-1:0] out_status,
  output logic [dht_pkg::DEG_W-1:0]  out_first_degree,
  output logic [dht_pkg::DEG_W-1:0]  out_second_degree,
  output logic [dht_pkg::CNT_W-1:0]  out_vertices_at_degree,
  output logic [dht_pkg::SUM_W-1:0]  out_degree_total,
  output logic [dht_pkg::EDGE_W-1:0] out_edge_total
);

  import dht_pkg::*;

  localparam logic [DEG_W:0] MAX_DEG_X = (DEG_W+1)'(MAX_DEGREE);
  localparam logic [CNT_W-1:0] CNT_ALL = CNT_W'(NUM_VERTICES);

  state_t state_r, state_nxt;
  logic [VTX_W-1:0] clr_cnt_r;

  mode_t            mode_r;
  logic [VTX_W-1:0] va_r, vb_r;
  logic [DEG_W-1:0] dv_r;
  logic [DEG_W-1:0] da_r, db_r, na_r, nb_r, fa_r, fb_r, cnt_addr_r;
  logic             qzero_r;
  status_t          status_r;
  logic [SUM_W-1:0] sum_r;
  logic [2:0]       nops_r;
  logic [1:0]       op_idx_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [DEG_W-1:0] out_fa_r, out_fb_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [SUM_W-1:0] out_sum_r;

  // RAM ports
  logic             vdeg_we, vdeg_re;
  logic [VTX_W-1:0] vdeg_waddr, vdeg_raddr;
  logic [DEG_W-1:0] vdeg_wdata, vdeg_rdata;
  logic             hist_we, hist_re;
  logic [DEG_W-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0] hist_wdata, hist_rdata;

  // evaluation of the move
  logic             self_c, ok_c, upd_one_c, upd_two_c;
  logic [DEG_W:0]   na_w, nb_w;
  logic [DEG_W-1:0] fa_c, fb_c;
  status_t          fail_c;
  logic [SUM_W-1:0] sum_c;
  logic [DEG_W-1:0] op_addr;
  logic             accept, out_free, out_load, ops_last;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DONE) && out_free;
  assign ops_last = ({1'b0, op_idx_r} == (nops_r - 3'd1));

  dht_ram #(.WIDTH(DEG_W), .DEPTH(NUM_VERTICES)) u_vdeg_ram (
    .clk   (clk),
    .we    (vdeg_we),
    .waddr (vdeg_waddr),
    .wdata (vdeg_wdata),
    .re    (vdeg_re),
    .raddr (vdeg_raddr),
    .rdata (vdeg_rdata)
  );

  dht_ram #(.WIDTH(CNT_W), .DEPTH(DEG_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  always_comb begin
    self_c    = (va_r == vb_r);
    ok_c      = 1'b1;
    upd_one_c = 1'b0;
    upd_two_c = 1'b0;
    na_w      = {1'b0, da_r};
    nb_w      = {1'b0, vdeg_rdata};
    fail_c    = STATUS_OVER;
    case (mode_r)
      MODE_ADD: begin
        if (self_c) begin
          na_w      = {1'b0, da_r} + (DEG_W+1)'(2);
          ok_c      = (na_w <= MAX_DEG_X);
          upd_one_c = ok_c;
        end else begin
          na_w      = {1'b0, da_r} + (DEG_W+1)'(1);
          nb_w      = {1'b0, vdeg_rdata} + (DEG_W+1)'(1);
          ok_c      = (na_w <= MAX_DEG_X) && (nb_w <= MAX_DEG_X);
          upd_two_c = ok_c;
        end
      end
      MODE_REMOVE: begin
        fail_c = STATUS_UNDER;
        if (self_c) begin
          na_w      = {1'b0, da_r} - (DEG_W+1)'(2);
          ok_c      = (da_r >= DEG_W'(2));
          upd_one_c = ok_c;
        end else begin
          na_w      = {1'b0, da_r} - (DEG_W+1)'(1);
          nb_w      = {1'b0, vdeg_rdata} - (DEG_W+1)'(1);
          ok_c      = (da_r != '0) && (vdeg_rdata != '0);
          upd_two_c = ok_c;
        end
      end
      MODE_SET: begin
        na_w      = {1'b0, dv_r};
        ok_c      = (na_w <= MAX_DEG_X);
        upd_one_c = ok_c;
      end
      default: begin
        ok_c = 1'b1;
      end
    endcase
    fa_c  = (upd_one_c || upd_two_c) ? na_w[DEG_W-1:0] : da_r;
    fb_c  = self_c ? fa_c : (upd_two_c ? nb_w[DEG_W-1:0] : vdeg_rdata);
    sum_c = sum_r - SUM_W'(da_r) + SUM_W'(na_w[DEG_W-1:0]);
    if (upd_two_c) begin
      sum_c = sum_c + SUM_W'(nb_w[DEG_W-1:0]) - SUM_W'(vdeg_rdata);
    end
  end

  always_comb begin
    case (op_idx_r)
      2'd0:    op_addr = da_r;
      2'd1:    op_addr = na_r;
      2'd2:    op_addr = db_r;
      default: op_addr = nb_r;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    vdeg_we    = 1'b0;
    vdeg_waddr = va_r;
    vdeg_wdata = na_r;
    vdeg_re    = 1'b0;
    vdeg_raddr = vb_r;
    hist_we    = 1'b0;
    hist_waddr = op_addr;
    hist_wdata = op_idx_r[0] ? (hist_rdata + CNT_W'(1)) : (hist_rdata - CNT_W'(1));
    hist_re    = 1'b0;
    hist_raddr = op_addr;
    unique case (state_r)
      S_CLR: begin
        vdeg_we    = 1'b1;
        vdeg_waddr = clr_cnt_r;
        vdeg_wdata = '0;
        hist_we    = 1'b1;
        hist_waddr = DEG_W'(clr_cnt_r);
        hist_wdata = (clr_cnt_r == '0) ? CNT_ALL : '0;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        vdeg_re    = in_valid;
        vdeg_raddr = in_first_vertex;
        if (in_valid) begin
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        vdeg_re   = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        vdeg_we    = upd_one_c || upd_two_c;
        vdeg_wdata = na_w[DEG_W-1:0];
        state_nxt  = (upd_one_c || upd_two_c) ? S_HRD : S_CRD;
      end
      S_HRD: begin
        hist_re   = 1'b1;
        state_nxt = S_HWR;
      end
      S_HWR: begin
        hist_we    = 1'b1;
        vdeg_we    = (op_idx_r == 2'd0) && (nops_r == 3'd4);
        vdeg_waddr = vb_r;
        vdeg_wdata = nb_r;
        state_nxt  = ops_last ? S_CRD : S_HRD;
      end
      S_CRD: begin
        hist_re    = 1'b1;
        hist_raddr = cnt_addr_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + VTX_W'(1);
      end
      if ((state_r == S_CALC) && (upd_one_c || upd_two_c)) begin
        sum_r <= sum_c;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      va_r   <= in_first_vertex;
      vb_r   <= in_second_vertex;
      dv_r   <= in_degree_value;
    end
    if (state_r == S_RDB) begin
      da_r <= vdeg_rdata;
    end
    if (state_r == S_CALC) begin
      db_r       <= vdeg_rdata;
      na_r       <= na_w[DEG_W-1:0];
      nb_r       <= nb_w[DEG_W-1:0];
      fa_r       <= fa_c;
      fb_r       <= fb_c;
      status_r   <= ok_c ? STATUS_OK : fail_c;
      cnt_addr_r <= (mode_r == MODE_QUERY) ? dv_r : fa_c;
      qzero_r    <= (mode_r == MODE_QUERY) && ({1'b0, dv_r} > MAX_DEG_X);
      nops_r     <= upd_two_c ? 3'd4 : (upd_one_c ? 3'd2 : 3'd0);
      op_idx_r   <= '0;
    end
    if (state_r == S_HWR) begin
      op_idx_r <= op_idx_r + 2'd1;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_fa_r     <= fa_r;
      out_fb_r     <= fb_r;
      out_cnt_r    <= qzero_r ? '0 : hist_rdata;
      out_sum_r    <= sum_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_first_degree       = out_fa_r;
  assign out_second_degree      = out_fb_r;
  assign out_vertices_at_degree = out_cnt_r;
  assign out_degree_total       = out_sum_r;
  assign out_edge_total         = out_sum_r[SUM_W-1:1];

  `DHT_ASSERT(a_no_overwrite, out_load |-> !(out_valid_r && out_stall), "result overwritten")
  `DHT_ASSERT(a_op_bound, (state_r == S_HWR) |-> ({1'b0, op_idx_r} < nops_r), "extra hist op")
  `DHT_ASSERT(a_hist_range, hist_we |-> (hist_wdata <= CNT_ALL), "histogram count out of range")
  `DHT_ASSERT(a_clr_quiet, (state_r == S_CLR) |-> (!out_valid_r && in_stall), "busy while clearing")

endmodule

@@ rtl/core/dht_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
